// ===== rtl/core/rfs_pkg.sv =====
package rfs_pkg;

   localparam int ACTION_W = 3;
   localparam int BASE_W   = 8;
   localparam int LEVEL_W  = 10;
   localparam int PROD_W   = BASE_W + LEVEL_W;
   localparam int MASK_W   = 4;
   localparam int FLEVEL_W = 4;
   localparam int COLOUR_W = 3;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [BASE_W-1:0]   base_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [PROD_W-1:0]   prod_type;
   typedef logic [MASK_W-1:0]   mask_type;

   localparam action_type ACT_FADE_TICK = 3'd0;
   localparam action_type ACT_TURN_ON   = 3'd1;
   localparam action_type ACT_WHITE_ON  = 3'd2;
   localparam action_type ACT_TURN_OFF  = 3'd3;
   localparam action_type ACT_STORE     = 3'd4;

   localparam logic CSR_INTENSITY = 1'b0;
   localparam logic CSR_MAX_LEVEL = 1'b1;

   localparam mask_type MASK_ALL   = 4'hF;
   localparam mask_type MASK_WHITE = 4'h8;

   localparam logic [FLEVEL_W-1:0] FADE_STEPS   = 4'd8;
   localparam logic [COLOUR_W-1:0] COLOUR_FIRST = 3'd1;
   localparam logic [COLOUR_W-1:0] COLOUR_LAST  = 3'd7;

   localparam base_type  INTENSITY_RESET  = 8'd255;
   localparam level_type MAX_LEVEL_RESET  = 10'd1023;
   localparam base_type  WHITE_BASE_RESET = 8'd200;
   localparam base_type  DIVISOR          = 8'd255;

   // Quotient by 255: the shifted sum never overshoots and falls short by at
   // most one, which the remainder compare puts right.
   function automatic level_type div255(input prod_type x);
      logic [PROD_W:0] sum;
      logic [PROD_W:0] q_est;
      logic [PROD_W:0] rem;
      begin
         sum   = {1'b0, x} + {9'b0, x[PROD_W-1:8]} + {17'b0, x[PROD_W-1:16]};
         q_est = sum >> 8;
         rem   = {1'b0, x} - ((q_est << 8) - q_est);
         if (rem >= {11'b0, DIVISOR}) begin
            q_est = q_est + 19'd1;
         end
         div255 = q_est[LEVEL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/rfs_req_if.sv =====
interface rfs_req_if;
   import rfs_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   base_type   red_in;
   base_type   green_in;
   base_type   blue_in;
   base_type   white_in;

   modport source (output valid, action, red_in, green_in, blue_in, white_in,
                   input ready);
   modport sink   (input valid, action, red_in, green_in, blue_in, white_in,
                   output ready);
endinterface

// ===== rtl/core/rfs_rsp_if.sv =====
interface rfs_rsp_if;
   import rfs_pkg::*;

   logic      valid;
   logic      ready;
   mask_type  write_mask;
   level_type red_level;
   level_type green_level;
   level_type blue_level;
   level_type white_level;

   modport source (output valid, write_mask, red_level, green_level, blue_level,
                   white_level, input ready);
   modport sink   (input valid, write_mask, red_level, green_level, blue_level,
                   white_level, output ready);
endinterface

// ===== rtl/core/rgbw_fade_sequencer.sv =====
// RGBW fade sequencer: turns commands into four PWM levels for an RGBW LED.
// Commands arrive as items on req_ch (fade tick, turn on, white on, turn off,
// store base values); each of the first four gives one item on rsp_ch with a
// write mask and four levels, while store values and unused codes give none.
// intensity and max_level are written through the csr_ port; the user must
// do so only while the block is idle, as the block does not enforce it.
// Scaling runs on one shared 8x10 multiplier followed by a shared
// divide-by-255 stage: a red, green or blue level takes a multiply and divide
// by intensity and then by max_level, the white level only the max_level one.
// Fade tick and turn on scale all four channels, white on only white; turn
// off gives zero levels without arithmetic, and store values only loads the
// bases. A new item is accepted once the previous one has reached the output
// register, so the block takes no new item before the last one is through.
// If the receiver stalls, the output register holds its item and the block
// still accepts and works on one more item, which then waits for the output.
// Synchronous reset sets intensity 255, max_level 1023, fade level 0 rising,
// target colour 1, red, green and blue bases 0 and white base 200.
module rgbw_fade_sequencer (
   input  logic              clock,
   input  logic              reset,
   rfs_req_if.sink           req_ch,
   rfs_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  rfs_pkg::level_type csr_wdata
);
   import rfs_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CALC   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [1:0] PH_MUL_INT = 2'd0;
   localparam logic [1:0] PH_DIV_INT = 2'd1;
   localparam logic [1:0] PH_MUL_MAX = 2'd2;
   localparam logic [1:0] PH_DIV_MAX = 2'd3;

   localparam logic [1:0] CH_WHITE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   logic [1:0]          ch_ff, ch_in;
   base_type            acc_ff, acc_in;
   prod_type            prod_ff, prod_in;
   level_type           lvl_ff [4];
   level_type           lvl_in [4];
   mask_type            mask_ff, mask_in;

   base_type            intensity_ff, intensity_in;
   level_type           max_ff, max_in;
   logic [FLEVEL_W-1:0] fade_level_ff, fade_level_in;
   logic                fade_rising_ff, fade_rising_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   base_type            base_ff [4];
   base_type            base_in [4];

   logic                rsp_valid_ff, rsp_valid_in;
   mask_type            out_mask_ff, out_mask_in;
   level_type           out_lvl_ff [4];
   level_type           out_lvl_in [4];

   logic                accept;
   logic                out_free;
   level_type           mul_b;
   prod_type            mul_out;
   level_type           div_out;
   logic [BASE_W:0]     fade_value;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Shared arithmetic: one multiplier and one divide-by-255 stage.
   assign mul_b   = (phase_ff == PH_MUL_INT) ? {2'b00, intensity_ff} : max_ff;
   assign mul_out = acc_ff * mul_b;
   assign div_out = div255(prod_ff);

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      ch_in          = ch_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      lvl_in         = lvl_ff;
      mask_in        = mask_ff;
      intensity_in   = intensity_ff;
      max_in         = max_ff;
      fade_level_in  = fade_level_ff;
      fade_rising_in = fade_rising_ff;
      colour_in      = colour_ff;
      base_in        = base_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      out_mask_in    = out_mask_ff;
      out_lvl_in     = out_lvl_ff;
      fade_value     = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_INTENSITY: intensity_in = csr_wdata[BASE_W-1:0];
            CSR_MAX_LEVEL: max_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lvl_in = '{default: '0};
               case (req_ch.action)
                  ACT_FADE_TICK: begin
                     if (fade_rising_ff) begin
                        if (fade_level_ff + 4'd1 >= FADE_STEPS) begin
                           fade_level_in  = FADE_STEPS;
                           fade_rising_in = 1'b0;
                        end else begin
                           fade_level_in = fade_level_ff + 4'd1;
                        end
                     end else if (fade_level_ff <= 4'd1) begin
                        fade_level_in  = '0;
                        fade_rising_in = 1'b1;
                        colour_in = (colour_ff == COLOUR_LAST) ? COLOUR_FIRST
                                                               : colour_ff + 3'd1;
                     end else begin
                        fade_level_in = fade_level_ff - 4'd1;
                     end
                     fade_value = (9'd1 << fade_level_in) - 9'd1;
                     base_in[0] = colour_in[0] ? fade_value[BASE_W-1:0] : '0;
                     base_in[1] = colour_in[1] ? fade_value[BASE_W-1:0] : '0;
                     base_in[2] = colour_in[2] ? fade_value[BASE_W-1:0] : '0;
                     mask_in  = MASK_ALL;
                     ch_in    = 2'd0;
                     phase_in = PH_MUL_INT;
                     acc_in   = base_in[0];
                     state_in = ST_CALC;
                  end
                  ACT_TURN_ON: begin
                     mask_in  = MASK_ALL;
                     ch_in    = 2'd0;
                     phase_in = PH_MUL_INT;
                     acc_in   = base_ff[0];
                     state_in = ST_CALC;
                  end
                  ACT_WHITE_ON: begin
                     mask_in  = MASK_WHITE;
                     ch_in    = CH_WHITE;
                     phase_in = PH_MUL_MAX;
                     acc_in   = base_ff[CH_WHITE];
                     state_in = ST_CALC;
                  end
                  ACT_TURN_OFF: begin
                     mask_in  = MASK_ALL;
                     state_in = ST_FINISH;
                  end
                  ACT_STORE: begin
                     base_in[0] = req_ch.red_in;
                     base_in[1] = req_ch.green_in;
                     base_in[2] = req_ch.blue_in;
                     base_in[3] = req_ch.white_in;
                  end
                  default: ;
               endcase
            end
         end
         ST_CALC: begin
            case (phase_ff)
               PH_MUL_INT: begin
                  prod_in  = mul_out;
                  phase_in = PH_DIV_INT;
               end
               PH_DIV_INT: begin
                  acc_in   = div_out[BASE_W-1:0];
                  phase_in = PH_MUL_MAX;
               end
               PH_MUL_MAX: begin
                  prod_in  = mul_out;
                  phase_in = PH_DIV_MAX;
               end
               PH_DIV_MAX: begin
                  lvl_in[ch_ff] = div_out;
                  if (ch_ff == CH_WHITE) begin
                     state_in = ST_FINISH;
                  end else begin
                     ch_in = ch_ff + 2'd1;
                     if (ch_in == CH_WHITE) begin
                        // White skips the intensity step.
                        phase_in = PH_MUL_MAX;
                     end else begin
                        phase_in = PH_MUL_INT;
                     end
                     acc_in = base_ff[ch_in];
                  end
               end
               default: ;
            endcase
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_mask_in  = mask_ff;
               out_lvl_in   = lvl_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         intensity_ff   <= INTENSITY_RESET;
         max_ff         <= MAX_LEVEL_RESET;
         fade_level_ff  <= '0;
         fade_rising_ff <= 1'b1;
         colour_ff      <= COLOUR_FIRST;
         base_ff[0]     <= '0;
         base_ff[1]     <= '0;
         base_ff[2]     <= '0;
         base_ff[3]     <= WHITE_BASE_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         intensity_ff   <= intensity_in;
         max_ff         <= max_in;
         fade_level_ff  <= fade_level_in;
         fade_rising_ff <= fade_rising_in;
         colour_ff      <= colour_in;
         base_ff        <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      ch_ff       <= ch_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      lvl_ff      <= lvl_in;
      mask_ff     <= mask_in;
      out_mask_ff <= out_mask_in;
      out_lvl_ff  <= out_lvl_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.write_mask  = out_mask_ff;
   assign rsp_ch.red_level   = out_lvl_ff[0];
   assign rsp_ch.green_level = out_lvl_ff[1];
   assign rsp_ch.blue_level  = out_lvl_ff[2];
   assign rsp_ch.white_level = out_lvl_ff[3];

   a_mask_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_mask_ff == MASK_ALL || out_mask_ff == MASK_WHITE))
      else $error("result item carries an unexpected write mask");

   a_white_only_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_mask_ff == MASK_WHITE) |->
         (out_lvl_ff[0] == '0 && out_lvl_ff[1] == '0 && out_lvl_ff[2] == '0))
      else $error("white-only item has a non-zero colour level");

   a_calc_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && phase_ff == PH_DIV_MAX && ch_ff == CH_WHITE) |=>
         state_ff == ST_FINISH)
      else $error("scaling did not hand over to the output stage");

   a_falling_nonzero: assert property (@(posedge clock) disable iff (reset)
      !fade_rising_ff |-> (fade_level_ff != '0 && fade_level_ff <= FADE_STEPS))
      else $error("fade is falling from an impossible level");

   a_colour_nonzero: assert property (@(posedge clock) disable iff (reset)
      accept |=> colour_ff != '0)
      else $error("target colour reached black");

endmodule

// ===== bench/rfs_fade_checker.sv =====
`timescale 1ns / 100ps

module rfs_fade_checker (
   input  logic               clock,
   input  logic               reset,
   rfs_req_if                 req_ch,
   rfs_rsp_if                 rsp_ch,
   input  logic               csr_we,
   input  logic               csr_index,
   input  rfs_pkg::level_type csr_wdata,
   output int                 fail_count,
   output int                 pending
);
   import rfs_pkg::*;

   typedef struct {
      mask_type  mask;
      level_type red;
      level_type green;
      level_type blue;
      level_type white;
   } led_levels_type;

   led_levels_type expected_levels[$];
   led_levels_type want;

   base_type             intensity;
   level_type            full_scale;
   logic [FLEVEL_W-1:0]  fade_step;
   logic                 fading_up;
   logic [COLOUR_W-1:0]  colour;
   base_type             red_base;
   base_type             green_base;
   base_type             blue_base;
   base_type             white_base;

   int mismatches = 0;
   int waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   function automatic level_type rgb_level(base_type v);
      int unsigned prod;
      if (v == 0 || intensity == 0) begin
         return '0;
      end
      prod = {24'b0, v};
      prod = prod * intensity / 255;
      prod = prod * full_scale / 255;
      return prod[LEVEL_W-1:0];
   endfunction

   function automatic level_type white_level(base_type v);
      int unsigned prod;
      prod = {24'b0, v};
      prod = prod * full_scale / 255;
      return prod[LEVEL_W-1:0];
   endfunction

   function automatic led_levels_type lit_levels();
      led_levels_type lv;
      lv.mask  = MASK_ALL;
      lv.red   = rgb_level(red_base);
      lv.green = rgb_level(green_base);
      lv.blue  = rgb_level(blue_base);
      lv.white = white_level(white_base);
      return lv;
   endfunction

   // The level climbs to the top step, falls back, and on reaching black the
   // target colour moves on, skipping the all-off colour when it wraps.
   task automatic step_fade();
      int unsigned ramp;
      base_type    v;
      if (fading_up) begin
         fade_step = fade_step + 1'b1;
         if (fade_step >= FADE_STEPS) begin
            fade_step = FADE_STEPS;
            fading_up = 1'b0;
         end
      end else if (fade_step <= 1) begin
         fade_step = '0;
         colour    = (colour == COLOUR_LAST) ? COLOUR_FIRST : colour + 1'b1;
         fading_up = 1'b1;
      end else begin
         fade_step = fade_step - 1'b1;
      end
      ramp       = (32'd1 << fade_step) - 32'd1;
      v          = ramp[BASE_W-1:0];
      red_base   = colour[0] ? v : '0;
      green_base = colour[1] ? v : '0;
      blue_base  = colour[2] ? v : '0;
   endtask

   task automatic apply_command(action_type act, base_type r, base_type g,
                                base_type b, base_type w);
      led_levels_type lv;
      case (act)
         ACT_FADE_TICK: begin
            step_fade();
            expected_levels.push_back(lit_levels());
         end
         ACT_TURN_ON: begin
            expected_levels.push_back(lit_levels());
         end
         ACT_WHITE_ON: begin
            lv.mask  = MASK_WHITE;
            lv.red   = '0;
            lv.green = '0;
            lv.blue  = '0;
            lv.white = white_level(white_base);
            expected_levels.push_back(lv);
         end
         ACT_TURN_OFF: begin
            lv.mask  = MASK_ALL;
            lv.red   = '0;
            lv.green = '0;
            lv.blue  = '0;
            lv.white = '0;
            expected_levels.push_back(lv);
         end
         ACT_STORE: begin
            red_base   = r;
            green_base = g;
            blue_base  = b;
            white_base = w;
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(string what, int want_v, int got_v);
      if (want_v != got_v) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         intensity  = INTENSITY_RESET;
         full_scale = MAX_LEVEL_RESET;
         fade_step  = '0;
         fading_up  = 1'b1;
         colour     = COLOUR_FIRST;
         red_base   = '0;
         green_base = '0;
         blue_base  = '0;
         white_base = WHITE_BASE_RESET;
         expected_levels.delete();
      end else begin
         // A result leaving at this edge belongs to an earlier item, so it is
         // matched before any item accepted at the same edge is predicted.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_levels.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing expected, mask %0h", $time,
                        rsp_ch.write_mask);
            end else begin
               want = expected_levels.pop_front();
               check_field("write_mask", want.mask, rsp_ch.write_mask);
               check_field("red_level", want.red, rsp_ch.red_level);
               check_field("green_level", want.green, rsp_ch.green_level);
               check_field("blue_level", want.blue, rsp_ch.blue_level);
               check_field("white_level", want.white, rsp_ch.white_level);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            apply_command(req_ch.action, req_ch.red_in, req_ch.green_in,
                          req_ch.blue_in, req_ch.white_in);
         end
         if (csr_we) begin
            if (csr_index == CSR_INTENSITY) begin
               intensity = csr_wdata[BASE_W-1:0];
            end else begin
               full_scale = csr_wdata;
            end
         end
      end
      waiting <= expected_levels.size();
   end

endmodule

// ===== bench/tb_rgbw_fade_sequencer.sv =====
`timescale 1ns / 100ps

module tb_rgbw_fade_sequencer;
   import rfs_pkg::*;

   logic      clock;
   logic      reset;
   logic      csr_we;
   logic      csr_index;
   level_type csr_wdata;
   logic      rsp_hold;
   int        pending;
   int        fail_count;

   rfs_req_if req_ch ();
   rfs_rsp_if rsp_ch ();

   rgbw_fade_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rfs_fade_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Half of all gaps are empty, most of the rest short, a few long.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 8) begin
         return 0;
      end else if (pick < 14) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 60);
   endfunction

   task automatic offer(action_type act, base_type r, base_type g, base_type b,
                        base_type w);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.red_in   <= r;
      req_ch.green_in <= g;
      req_ch.blue_in  <= b;
      req_ch.white_in <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Mostly fade ticks, so that the sequencer runs through every colour.
   task automatic random_command();
      int         pick;
      action_type act;
      base_type   r, g, b, w;
      pick = $urandom_range(0, 99);
      r    = base_type'($urandom);
      g    = base_type'($urandom);
      b    = base_type'($urandom);
      w    = base_type'($urandom);
      if (pick < 55) begin
         act = ACT_FADE_TICK;
      end else if (pick < 63) begin
         act = ACT_TURN_ON;
      end else if (pick < 71) begin
         act = ACT_WHITE_ON;
      end else if (pick < 79) begin
         act = ACT_TURN_OFF;
      end else if (pick < 95) begin
         act = ACT_STORE;
         if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = r;
            b = r;
            w = r;
         end
      end else begin
         act = action_type'($urandom_range(5, 7));
      end
      offer(act, r, g, b, w);
   endtask

   // The block must be idle: all results in, and time for any store item
   // still in flight to finish.
   task automatic program_levels(level_type gain, level_type top);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_INTENSITY;
      csr_wdata <= gain;
      @(posedge clock);
      csr_index <= CSR_MAX_LEVEL;
      csr_wdata <= top;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int        stall_left;
      int        run_left;
      stall_left   = 0;
      run_left     = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && run_left == 0) begin
            stall_left = idle_cycles();
            run_left   = $urandom_range(1, 40);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            run_left--;
            rsp_ch.ready <= !rsp_hold;
         end
      end
   end

   // A long hold on the result side while items keep being offered, so the
   // block fills up and has to stall its input.
   initial begin
      rsp_hold = 1'b0;
      repeat (3000) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("tb_rgbw_fade_sequencer: done, errors");
      $finish;
   end

   initial begin
      level_type gains[6];
      level_type tops[6];
      gains = '{10'd0, 10'd255, 10'd1, 10'd128, 10'd0, 10'd255};
      tops  = '{10'd1023, 10'd0, 10'd1, 10'd512, 10'd0, 10'd1023};
      gains[4] = level_type'($urandom);
      tops[4]  = level_type'($urandom);

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_INTENSITY;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_FADE_TICK;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      req_ch.white_in = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, on the register values that reset leaves.
      offer(ACT_TURN_ON, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_WHITE_ON, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_TURN_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(ACT_FADE_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_FADE_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(ACT_STORE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(ACT_TURN_ON, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_WHITE_ON, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_STORE, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_TURN_ON, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(ACT_WHITE_ON, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(ACT_STORE, 8'hAA, 8'h55, 8'h01, 8'h80);
      offer(ACT_TURN_ON, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_FADE_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(action_type'(5), 8'hFF, 8'h00, 8'hFF, 8'h00);
      offer(action_type'(6), 8'h00, 8'hFF, 8'h00, 8'hFF);
      offer(action_type'(7), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      offer(ACT_TURN_ON, 8'h00, 8'h00, 8'h00, 8'h00);
      offer(ACT_STORE, 8'h55, 8'hAA, 8'hFE, 8'h7F);
      offer(ACT_WHITE_ON, 8'h00, 8'h00, 8'h00, 8'h00);

      for (int p = 0; p < 6; p++) begin
         program_levels(gains[p], tops[p]);
         repeat (315) random_command();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_rgbw_fade_sequencer: done, clean");
      end else begin
         $display("tb_rgbw_fade_sequencer: done, errors");
      end
      $finish;
   end

endmodule

// ===== rgbw_fade_sequencer.f =====
rtl/core/rfs_pkg.sv
rtl/core/rfs_req_if.sv
rtl/core/rfs_rsp_if.sv
rtl/core/rgbw_fade_sequencer.sv
bench/rfs_fade_checker.sv
bench/tb_rgbw_fade_sequencer.sv
